### src/esd_pkg.sv
// Types, constants and helper functions shared by the escape sequence decoder.
// No dependencies.
`timescale 1ns / 1ps

package esd_pkg;

   localparam logic [15:0] CH_BACKSLASH = 16'h005C;
   localparam logic [15:0] CH_LOWER_X   = 16'h0078;
   localparam logic [15:0] CH_LOWER_U   = 16'h0075;
   localparam int unsigned RSP_DEPTH    = 2;

   typedef enum logic [3:0] {
      MODE_PLAIN = 4'd0,
      MODE_ESC   = 4'd1,
      MODE_OCT1  = 4'd2,
      MODE_OCT2  = 4'd3,
      MODE_HEX0  = 4'd4,
      MODE_HEX1  = 4'd5,
      MODE_UNI0  = 4'd6,
      MODE_UNI1  = 4'd7,
      MODE_UNI2  = 4'd8,
      MODE_UNI3  = 4'd9
   } mode_type;

   typedef struct packed {
      logic [15:0] out_char;
      logic        has_char;
      logic        out_last;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type item0;
      rsp_item_type item1;
   } dec_out_type;

   function automatic logic is_octal(input logic [15:0] c);
      return (c >= 16'h0030) && (c <= 16'h0037);
   endfunction

   // {valid, digit value}
   function automatic logic [4:0] hex_value(input logic [15:0] c);
      logic [4:0] r;
      r = 5'd0;
      if ((c >= 16'h0030) && (c <= 16'h0039)) begin
         r = {1'b1, c[3:0]};
      end else if (((c >= 16'h0061) && (c <= 16'h0066)) ||
                   ((c >= 16'h0041) && (c <= 16'h0046))) begin
         r = {1'b1, c[3:0] + 4'd9};
      end
      return r;
   endfunction

   // {hit, control code}
   function automatic logic [6:0] control_code(input logic [15:0] c);
      logic [6:0] r;
      r = 7'd0;
      case (c)
         16'h0061: r = {1'b1, 6'd7};
         16'h0062: r = {1'b1, 6'd8};
         16'h0066: r = {1'b1, 6'd12};
         16'h006E: r = {1'b1, 6'd10};
         16'h0072: r = {1'b1, 6'd13};
         16'h0073: r = {1'b1, 6'd32};
         16'h0074: r = {1'b1, 6'd9};
         16'h0076: r = {1'b1, 6'd11};
         default:  r = 7'd0;
      endcase
      return r;
   endfunction

endpackage

### src/esd_if.sv
// Valid/ready channel interfaces for the request and response streams.
// Depends on nothing.
`timescale 1ns / 1ps

interface esd_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] in_char;
   logic        in_last;

   modport source (output valid, output in_char, output in_last, input ready);
   modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

interface esd_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] out_char;
   logic        has_char;
   logic        out_last;

   modport source (output valid, output out_char, output has_char, output out_last,
                   input ready);
   modport sink   (input valid, input out_char, input has_char, input out_last,
                   output ready);
endinterface

### src/esd_decode.sv
// Request register, escape state and the single-pass decode of one character.
// Depends on esd_pkg.
`timescale 1ns / 1ps

module esd_decode
   import esd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_char,
   input  logic        req_last,
   input  logic [1:0]  free_slots,
   output dec_out_type dec
);

   logic        in_valid_ff, in_valid_in;
   logic [15:0] in_char_ff;
   logic        in_last_ff;
   mode_type    mode_ff, mode_in;
   logic [15:0] pend_ff, pend_in;

   logic         fire;
   logic [4:0]   hv;
   logic [6:0]   cc;
   logic [1:0]   n;
   rsp_item_type items [RSP_DEPTH];

   always_comb begin
      hv       = hex_value(in_char_ff);
      cc       = control_code(in_char_ff);
      mode_in  = mode_ff;
      pend_in  = pend_ff;
      n        = 2'd0;
      items[0] = '0;
      items[1] = '0;
      unique case (mode_ff) inside
         MODE_ESC: begin
            if (is_octal(in_char_ff)) begin
               pend_in = {13'd0, in_char_ff[2:0]};
               mode_in = MODE_OCT1;
            end else if (in_char_ff == CH_LOWER_X) begin
               mode_in = MODE_HEX0;
            end else if (in_char_ff == CH_LOWER_U) begin
               mode_in = MODE_UNI0;
            end else begin
               items[0] = '{out_char: cc[6] ? {10'd0, cc[5:0]} : in_char_ff,
                            has_char: 1'b1, out_last: 1'b0};
               n        = 2'd1;
               mode_in  = MODE_PLAIN;
            end
         end
         MODE_OCT1, MODE_OCT2: begin
            if (is_octal(in_char_ff)) begin
               pend_in = {pend_ff[12:0], in_char_ff[2:0]};
               if (mode_ff == MODE_OCT2) begin
                  items[0] = '{out_char: pend_in, has_char: 1'b1, out_last: 1'b0};
                  n        = 2'd1;
                  mode_in  = MODE_PLAIN;
               end else begin
                  mode_in = MODE_OCT2;
               end
            end else begin
               items[0] = '{out_char: pend_ff, has_char: 1'b1, out_last: 1'b0};
               n        = 2'd1;
               if (in_char_ff == CH_BACKSLASH) begin
                  mode_in = MODE_ESC;
               end else begin
                  items[1] = '{out_char: in_char_ff, has_char: 1'b1, out_last: 1'b0};
                  n        = 2'd2;
                  mode_in  = MODE_PLAIN;
               end
            end
         end
         MODE_HEX0, MODE_UNI0: begin
            if (hv[4]) begin
               pend_in = {12'd0, hv[3:0]};
               mode_in = (mode_ff == MODE_HEX0) ? MODE_HEX1 : MODE_UNI1;
            end else if (in_char_ff == CH_BACKSLASH) begin
               mode_in = MODE_ESC;
            end else begin
               items[0] = '{out_char: in_char_ff, has_char: 1'b1, out_last: 1'b0};
               n        = 2'd1;
               mode_in  = MODE_PLAIN;
            end
         end
         MODE_HEX1, MODE_UNI1, MODE_UNI2, MODE_UNI3: begin
            if (hv[4]) begin
               pend_in = {pend_ff[11:0], hv[3:0]};
               if ((mode_ff == MODE_HEX1) || (mode_ff == MODE_UNI3)) begin
                  items[0] = '{out_char: pend_in, has_char: 1'b1, out_last: 1'b0};
                  n        = 2'd1;
                  mode_in  = MODE_PLAIN;
               end else begin
                  mode_in = (mode_ff == MODE_UNI1) ? MODE_UNI2 : MODE_UNI3;
               end
            end else begin
               items[0] = '{out_char: pend_ff, has_char: 1'b1, out_last: 1'b0};
               n        = 2'd1;
               if (in_char_ff == CH_BACKSLASH) begin
                  mode_in = MODE_ESC;
               end else begin
                  items[1] = '{out_char: in_char_ff, has_char: 1'b1, out_last: 1'b0};
                  n        = 2'd2;
                  mode_in  = MODE_PLAIN;
               end
            end
         end
         default: begin
            if (in_char_ff == CH_BACKSLASH) begin
               mode_in = MODE_ESC;
            end else begin
               items[0] = '{out_char: in_char_ff, has_char: 1'b1, out_last: 1'b0};
               n        = 2'd1;
            end
         end
      endcase

      if (in_last_ff) begin
         // flush any partial numeric value at end of string
         if ((mode_in == MODE_OCT1) || (mode_in == MODE_OCT2) ||
             (mode_in == MODE_HEX1) || (mode_in == MODE_UNI1) ||
             (mode_in == MODE_UNI2) || (mode_in == MODE_UNI3)) begin
            items[n[0]] = '{out_char: pend_in, has_char: 1'b1, out_last: 1'b0};
            n           = n + 2'd1;
         end
         mode_in = MODE_PLAIN;
         if (n == 2'd0) begin
            items[0] = '{out_char: 16'd0, has_char: 1'b0, out_last: 1'b1};
            n        = 2'd1;
         end else begin
            items[~n[0]].out_last = 1'b1;
         end
      end
   end

   assign fire        = in_valid_ff && (n <= free_slots);
   assign req_ready   = !in_valid_ff || fire;
   assign in_valid_in = req_valid || (in_valid_ff && !fire);

   assign dec.count = fire ? n : 2'd0;
   assign dec.item0 = items[0];
   assign dec.item1 = items[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         mode_ff     <= MODE_PLAIN;
         pend_ff     <= 16'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (fire) begin
            mode_ff <= mode_in;
            pend_ff <= pend_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_char_ff <= req_char;
         in_last_ff <= req_last;
      end
   end

   a_last_returns_plain: assert property (@(posedge clock) disable iff (reset)
      (fire && in_last_ff) |=> (mode_ff == MODE_PLAIN))
      else $error("mode not plain after end of string");
   a_last_has_result: assert property (@(posedge clock) disable iff (reset)
      (fire && in_last_ff) |-> (dec.count != 2'd0))
      else $error("end of string produced no response");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      fire |-> (n != 2'd3))
      else $error("more than two responses for one request");

endmodule

### src/esd_rsp_queue.sv
// Two-entry response register queue; presents the head on the response channel.
// Depends on esd_pkg.
`timescale 1ns / 1ps

module esd_rsp_queue
   import esd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  dec_out_type  dec,
   output logic [1:0]   free_slots,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_item
);

   rsp_item_type q_ff [RSP_DEPTH];
   rsp_item_type q_in [RSP_DEPTH];
   logic [1:0]   count_ff, count_in;
   logic [1:0]   count_mid;
   logic         pop;

   assign rsp_valid  = (count_ff != 2'd0);
   assign rsp_item   = q_ff[0];
   assign pop        = rsp_valid && rsp_ready;
   assign free_slots = 2'(RSP_DEPTH) - count_ff + {1'b0, pop};

   always_comb begin
      q_in[0]   = q_ff[0];
      q_in[1]   = q_ff[1];
      count_mid = count_ff;
      if (pop) begin
         q_in[0]   = q_ff[1];
         count_mid = count_ff - 2'd1;
      end
      if (dec.count != 2'd0) begin
         q_in[count_mid[0]] = dec.item0;
      end
      if (dec.count == 2'd2) begin
         q_in[1] = dec.item1;
      end
      count_in = count_mid + dec.count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff[0] <= q_in[0];
      q_ff[1] <= q_in[1];
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("response queue count out of range");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      dec.count <= free_slots)
      else $error("response queue overflow");
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (pop && (dec.count == 2'd0) && (count_ff == 2'd1)) |=> (count_ff == 2'd0))
      else $error("response queue failed to drain");

endmodule

### src/escape_sequence_decoder_core.sv
// Top level of the escape sequence decoder: request register and decode, then
// a two-entry response queue. Depends on esd_pkg, esd_if, esd_decode, esd_rsp_queue.
`timescale 1ns / 1ps

// Channel    Dir  Payload                       Handshake
// req_chan   in   in_char[15:0], in_last         valid/ready
// rsp_chan   out  out_char[15:0], has_char, out_last  valid/ready
//
// One request per cycle while the response queue has room; a request passes through the
// request register, then the response queue, before its first response. A request that
// yields two responses queues both, and the single response port drains one entry per cycle while rsp_chan is ready.
// Synchronous active-high reset clears escape state, valids and queue count.
// Backpressure on rsp_chan fills the queue, then stalls req_chan.

module escape_sequence_decoder_core
   import esd_pkg::*;
(
   input  logic clock,
   input  logic reset,
   esd_req_if.sink   req_chan,
   esd_rsp_if.source rsp_chan
);

   dec_out_type  dec;
   logic [1:0]   free_slots;
   rsp_item_type rsp_item;

   esd_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_ready  (req_chan.ready),
      .req_char   (req_chan.in_char),
      .req_last   (req_chan.in_last),
      .free_slots (free_slots),
      .dec        (dec)
   );

   esd_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .dec        (dec),
      .free_slots (free_slots),
      .rsp_valid  (rsp_chan.valid),
      .rsp_ready  (rsp_chan.ready),
      .rsp_item   (rsp_item)
   );

   assign rsp_chan.out_char = rsp_item.out_char;
   assign rsp_chan.has_char = rsp_item.has_char;
   assign rsp_chan.out_last = rsp_item.out_last;

endmodule

### bench/tb_escape_sequence_decoder_core.sv
// Self-checking bench for escape_sequence_decoder_core: a directed table, then random
// escaped strings, checked against an in-bench decoder under random backpressure.
// Depends on esd_pkg, esd_if and the core.
`timescale 1ns / 1ps

module tb_escape_sequence_decoder_core;
   import esd_pkg::*;

   localparam int TABLE_ROWS   = 25;
   localparam int RANDOM_ITEMS = 1700;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 20;

   typedef enum logic [1:0] {
      ROW_PREDICT = 2'd0,
      ROW_NONE    = 2'd1,
      ROW_ONE     = 2'd2
   } row_kind_type;

   typedef struct packed {
      logic [15:0]  ch;
      logic         last;
      row_kind_type kind;
      rsp_item_type r;
   } stim_row_type;

   typedef struct packed {
      row_kind_type kind;
      rsp_item_type r;
   } typed_rsp_type;

   logic clock;
   logic reset;

   esd_req_if req_bus ();
   esd_rsp_if rsp_bus ();

   escape_sequence_decoder_core i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   mode_type        dec_mode  = MODE_PLAIN;
   logic [15:0]     dec_value = 16'h0000;
   rsp_item_type    decoded_q[$];
   rsp_item_type    expected_q[$];
   typed_rsp_type   typed_q[$];
   typed_rsp_type   typed_rec;
   stim_row_type    stim_table [0:TABLE_ROWS-1];
   logic [15:0]     str_q[$];
   logic [15:0]     ctl_letters [0:7];
   int              error_count = 0;
   int              sent_count  = 0;
   int              burst_left  = 0;
   bit              long_hold   = 1'b0;

   initial clock = 1'b0;
   always #1 clock = ~clock;

   function automatic void add_rsp(ref rsp_item_type q[$], input rsp_item_type r);
      q.insert(q.size(), r);
   endfunction

   // Bit-accurate decode of one request; updates the escape state.
   function automatic void decode_char(input logic [15:0] c, input logic last,
                                       ref rsp_item_type res[$]);
      mode_type    m;
      logic        oct_ok;
      logic        hex_ok;
      logic [3:0]  dig;
      logic        ctl_hit;
      logic [15:0] ctl;
      m = dec_mode;
      res.delete();
      oct_ok = (c >= 16'h0030) && (c <= 16'h0037);
      hex_ok = 1'b1;
      dig    = 4'd0;
      if ((c >= 16'h0030) && (c <= 16'h0039)) dig = 4'(c - 16'h0030);
      else if ((c >= 16'h0061) && (c <= 16'h0066)) dig = 4'(c - 16'h0061 + 16'd10);
      else if ((c >= 16'h0041) && (c <= 16'h0046)) dig = 4'(c - 16'h0041 + 16'd10);
      else hex_ok = 1'b0;
      ctl_hit = 1'b1;
      case (c)
         16'h0061: ctl = 16'd7;
         16'h0062: ctl = 16'd8;
         16'h0066: ctl = 16'd12;
         16'h006E: ctl = 16'd10;
         16'h0072: ctl = 16'd13;
         16'h0073: ctl = 16'd32;
         16'h0074: ctl = 16'd9;
         16'h0076: ctl = 16'd11;
         default: begin
            ctl     = 16'd0;
            ctl_hit = 1'b0;
         end
      endcase

      case (m) inside
         MODE_ESC: begin
            if (oct_ok) begin
               dec_value = c - 16'h0030;
               m = MODE_OCT1;
            end else if (c == CH_LOWER_X) begin
               m = MODE_HEX0;
            end else if (c == CH_LOWER_U) begin
               m = MODE_UNI0;
            end else begin
               add_rsp(res, {ctl_hit ? ctl : c, 1'b1, 1'b0});
               m = MODE_PLAIN;
            end
         end
         MODE_OCT1, MODE_OCT2: begin
            if (oct_ok) begin
               dec_value = {dec_value[12:0], 3'b000} + (c - 16'h0030);
               if (m == MODE_OCT2) begin
                  add_rsp(res, {dec_value, 1'b1, 1'b0});
                  m = MODE_PLAIN;
               end else begin
                  m = MODE_OCT2;
               end
            end else begin
               add_rsp(res, {dec_value, 1'b1, 1'b0});
               if (c == CH_BACKSLASH) m = MODE_ESC;
               else begin
                  add_rsp(res, {c, 1'b1, 1'b0});
                  m = MODE_PLAIN;
               end
            end
         end
         MODE_HEX0, MODE_UNI0: begin
            if (hex_ok) begin
               dec_value = {12'h000, dig};
               m = mode_type'(m + 4'd1);
            end else if (c == CH_BACKSLASH) begin
               m = MODE_ESC;
            end else begin
               add_rsp(res, {c, 1'b1, 1'b0});
               m = MODE_PLAIN;
            end
         end
         MODE_HEX1, MODE_UNI1, MODE_UNI2, MODE_UNI3: begin
            if (hex_ok) begin
               dec_value = {dec_value[11:0], dig};
               if (m == MODE_HEX1 || m == MODE_UNI3) begin
                  add_rsp(res, {dec_value, 1'b1, 1'b0});
                  m = MODE_PLAIN;
               end else begin
                  m = mode_type'(m + 4'd1);
               end
            end else begin
               add_rsp(res, {dec_value, 1'b1, 1'b0});
               if (c == CH_BACKSLASH) m = MODE_ESC;
               else begin
                  add_rsp(res, {c, 1'b1, 1'b0});
                  m = MODE_PLAIN;
               end
            end
         end
         default: begin
            if (c == CH_BACKSLASH) m = MODE_ESC;
            else add_rsp(res, {c, 1'b1, 1'b0});
         end
      endcase

      if (last) begin
         if (m == MODE_OCT1 || m == MODE_OCT2 || m == MODE_HEX1 ||
             m == MODE_UNI1 || m == MODE_UNI2 || m == MODE_UNI3) begin
            add_rsp(res, {dec_value, 1'b1, 1'b0});
         end
         m = MODE_PLAIN;
         if (res.size() == 0) add_rsp(res, {16'h0000, 1'b0, 1'b1});
         else res[res.size()-1].out_last = 1'b1;
      end
      dec_mode = m;
   endfunction

   function automatic logic [15:0] pick_hex();
      case ($urandom_range(0, 2))
         0:       return 16'h0030 + 16'($urandom_range(0, 9));
         1:       return 16'h0061 + 16'($urandom_range(0, 5));
         default: return 16'h0041 + 16'($urandom_range(0, 5));
      endcase
   endfunction

   function automatic logic [15:0] pick_char();
      case ($urandom_range(0, 4))
         0:       return 16'h0021 + 16'($urandom_range(0, 93));
         1:       return 16'($urandom_range(1, 65535));
         2:       return pick_hex();
         3:       return ctl_letters[$urandom_range(0, 7)];
         default: begin
            case ($urandom_range(0, 4))
               0:       return CH_LOWER_X;
               1:       return CH_LOWER_U;
               2:       return 16'h0038;
               3:       return 16'h0039;
               default: return CH_BACKSLASH;
            endcase
         end
      endcase
   endfunction

   // Request and response monitor.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            typed_rec = typed_q.size() != 0 ? typed_q.pop_front()
                                            : typed_rsp_type'{ROW_PREDICT, '0};
            decode_char(req_bus.in_char, req_bus.in_last, decoded_q);
            case (typed_rec.kind)
               ROW_NONE: ;
               ROW_ONE:  add_rsp(expected_q, typed_rec.r);
               default:  foreach (decoded_q[i]) add_rsp(expected_q, decoded_q[i]);
            endcase
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected response char=%h has=%b last=%b", $realtime,
                        rsp_bus.out_char, rsp_bus.has_char, rsp_bus.out_last);
               error_count++;
            end else begin
               typed_rec.r = expected_q.pop_front();
               if (rsp_bus.out_char !== typed_rec.r.out_char ||
                   rsp_bus.has_char !== typed_rec.r.has_char ||
                   rsp_bus.out_last !== typed_rec.r.out_last) begin
                  $display("%0t: expected char=%h has=%b last=%b, actual %h %b %b",
                           $realtime, typed_rec.r.out_char, typed_rec.r.has_char,
                           typed_rec.r.out_last, rsp_bus.out_char, rsp_bus.has_char,
                           rsp_bus.out_last);
                  error_count++;
               end
            end
         end
      end
   end

   // Receiver: stall pattern changes per window, plus one long hold-off on demand.
   initial begin : receiver
      int style;
      int window_left;
      style       = 0;
      window_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            long_hold = 1'b0;
         end else begin
            if (window_left == 0) begin
               style       = $urandom_range(0, 3);
               window_left = $urandom_range(16, 80);
            end
            window_left--;
            case (style)
               0:       rsp_bus.ready <= 1'b1;
               1:       rsp_bus.ready <= 1'($urandom_range(0, 1));
               2:       rsp_bus.ready <= ($urandom_range(0, 3) != 0);
               default: rsp_bus.ready <= ($urandom_range(0, 7) == 0);
            endcase
         end
      end
   end

   task automatic send_request(input logic [15:0] c, input logic last,
                               input row_kind_type kind, input rsp_item_type r);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = (long_hold || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      typed_q.insert(typed_q.size(), {kind, r});
      req_bus.valid   <= 1'b1;
      req_bus.in_char <= c;
      req_bus.in_last <= last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sent_count++;
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (expected_q.size() != 0);
   endtask

   initial begin : stimulus
      int n_tok;
      int kind;
      bit hold_done;
      hold_done = 1'b0;
      ctl_letters = '{16'h0061, 16'h0062, 16'h0066, 16'h006E,
                      16'h0072, 16'h0073, 16'h0074, 16'h0076};
      stim_table = '{
         '{16'h0001, 1'b1, ROW_ONE,     '{16'h0001, 1'b1, 1'b1}},
         '{16'hFFFF, 1'b1, ROW_ONE,     '{16'hFFFF, 1'b1, 1'b1}},
         '{16'h005C, 1'b1, ROW_ONE,     '{16'h0000, 1'b0, 1'b1}},
         '{16'h005C, 1'b0, ROW_NONE,    '0},
         '{16'h006E, 1'b1, ROW_ONE,     '{16'h000A, 1'b1, 1'b1}},
         '{16'h005C, 1'b0, ROW_NONE,    '0},
         '{16'h0037, 1'b0, ROW_NONE,    '0},
         '{16'h0037, 1'b0, ROW_NONE,    '0},
         '{16'h0037, 1'b1, ROW_ONE,     '{16'h01FF, 1'b1, 1'b1}},
         '{16'h005C, 1'b0, ROW_NONE,    '0},
         '{16'h0075, 1'b1, ROW_ONE,     '{16'h0000, 1'b0, 1'b1}},
         '{16'h005C, 1'b0, ROW_PREDICT, '0},
         '{16'h0078, 1'b0, ROW_PREDICT, '0},
         '{16'h0066, 1'b0, ROW_PREDICT, '0},
         '{16'h005C, 1'b0, ROW_PREDICT, '0},
         '{16'h0062, 1'b1, ROW_PREDICT, '0},
         '{16'h005C, 1'b0, ROW_PREDICT, '0},
         '{16'h0031, 1'b0, ROW_PREDICT, '0},
         '{16'h0038, 1'b1, ROW_PREDICT, '0},
         '{16'h005C, 1'b0, ROW_PREDICT, '0},
         '{16'h0075, 1'b0, ROW_PREDICT, '0},
         '{16'h0041, 1'b0, ROW_PREDICT, '0},
         '{16'h0062, 1'b0, ROW_PREDICT, '0},
         '{16'h0063, 1'b0, ROW_PREDICT, '0},
         '{16'h0044, 1'b1, ROW_PREDICT, '0}
      };

      reset           <= 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.in_char <= 16'h0041;
      req_bus.in_last <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < TABLE_ROWS; i++) begin
         send_request(stim_table[i].ch, stim_table[i].last, stim_table[i].kind,
                      stim_table[i].r);
      end

      while (sent_count < TABLE_ROWS + RANDOM_ITEMS) begin
         str_q.delete();
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 8)) str_q.insert(str_q.size(), pick_char());
         end else begin
            n_tok = $urandom_range(1, 5);
            repeat (n_tok) begin
               kind = $urandom_range(0, 7);
               if (kind != 0 && kind != 7) str_q.insert(str_q.size(), CH_BACKSLASH);
               case (kind)
                  1: str_q.insert(str_q.size(), ctl_letters[$urandom_range(0, 7)]);
                  2: repeat ($urandom_range(1, 4))
                        str_q.insert(str_q.size(), 16'h0030 + 16'($urandom_range(0, 7)));
                  3: begin
                     str_q.insert(str_q.size(), CH_LOWER_X);
                     repeat ($urandom_range(0, 3)) str_q.insert(str_q.size(), pick_hex());
                  end
                  4: begin
                     str_q.insert(str_q.size(), CH_LOWER_U);
                     repeat ($urandom_range(0, 5)) str_q.insert(str_q.size(), pick_hex());
                  end
                  5: str_q.insert(str_q.size(), pick_char());
                  6: begin
                     str_q.insert(str_q.size(), 16'h0030 + 16'($urandom_range(0, 7)));
                     str_q.insert(str_q.size(), $urandom_range(0, 2) == 0 ? CH_BACKSLASH :
                                  16'h0038 + 16'($urandom_range(0, 1)));
                  end
                  7: repeat ($urandom_range(1, 4)) str_q.insert(str_q.size(), pick_char());
                  default: str_q.insert(str_q.size(), pick_char());
               endcase
            end
         end
         foreach (str_q[i]) begin
            send_request(str_q[i], i == str_q.size() - 1, ROW_PREDICT, '0);
         end
         if (!hold_done && sent_count > 600) begin
            hold_done = 1'b1;
            long_hold = 1'b1;
         end
         if ($urandom_range(0, 49) == 0) wait_drained();
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_q.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         if (expected_q.size() != 0)
            $display("%0t: %0d expected responses never arrived", $realtime, expected_q.size());
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin : watchdog
      #1000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
